>>> rtl/grid_table_trilinear_lookup_assert.svh
// Assertion macros for the grid table lookup block
`ifndef GRID_TABLE_TRILINEAR_LOOKUP_ASSERT_SVH
`define GRID_TABLE_TRILINEAR_LOOKUP_ASSERT_SVH
`ifndef SYNTHESIS
`define GT_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define GT_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define GT_ASSERT_IMPL(label, clk, rst, ante, cons)
`define GT_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/gtl_pkg.sv
package gtl_pkg;
  localparam logic [1:0] OP_LOAD    = 2'd0;
  localparam logic [1:0] OP_NEAREST = 2'd1;
  localparam logic [1:0] OP_INTERP  = 2'd2;

  localparam logic [2:0] REG_INC_ORIGIN = 3'd0;
  localparam logic [2:0] REG_INC_RECIP  = 3'd1;
  localparam logic [2:0] REG_INC_POINTS = 3'd2;
  localparam logic [2:0] REG_SPD_ORIGIN = 3'd3;
  localparam logic [2:0] REG_SPD_RECIP  = 3'd4;
  localparam logic [2:0] REG_SPD_POINTS = 3'd5;
  localparam logic [2:0] REG_AZI_POINTS = 3'd6;
  localparam logic [2:0] REG_POL_POINTS = 3'd7;

  // Register file contents as seen by the datapath
  typedef struct packed {
    logic signed [31:0] inc_origin;
    logic [31:0]        inc_recip;
    logic [4:0]         inc_points;
    logic signed [31:0] spd_origin;
    logic [31:0]        spd_recip;
    logic [5:0]         spd_points;
    logic [5:0]         azi_points;
    logic [1:0]         pol_points;
  } cfg_t;
endpackage

>>> rtl/gtl_lerp.sv
// One blending step: lo + floor(((hi-lo)*a + 2^15) / 2^16), saturated.
// Two register stages: multiply, then round and saturate.
module gtl_lerp #(
  parameter int VW = 32
) (
  input  logic                 clk,
  input  logic signed [VW-1:0] lo,
  input  logic signed [VW-1:0] hi,
  input  logic signed [25:0]   frac,
  output logic signed [VW-1:0] res
);
  localparam int PW = VW + 27;
  logic signed [VW:0]   diff;
  logic signed [PW-1:0] prod;
  logic signed [VW-1:0] lo_d;
  logic signed [PW-1:0] rnd;
  logic signed [PW-1:0] sum;
  logic signed [PW-1:0] vmax;
  logic signed [PW-1:0] vmin;

  assign diff = VW'(0) + {hi[VW-1], hi} - {lo[VW-1], lo};

  // Multiply the difference by the fraction
  always_ff @(posedge clk) begin
    prod <= PW'(diff) * PW'(frac);
    lo_d <= lo;
  end

  // Round, add base and saturate
  always_comb begin
    rnd  = (prod + PW'(32768)) >>> 16;
    sum  = rnd + PW'(lo_d);
    vmax = PW'({1'b0, {(VW-1){1'b1}}});
    vmin = -vmax - PW'(1);
  end

  always_ff @(posedge clk) begin
    if (sum > vmax) begin
      res <= vmax[VW-1:0];
    end else if (sum < vmin) begin
      res <= vmin[VW-1:0];
    end else begin
      res <= sum[VW-1:0];
    end
  end
endmodule

>>> rtl/gtl_index.sv
// Turn one linear coordinate into nearest index, bracket and fraction.
// Stages: difference, product, index decisions.
module gtl_index #(
  parameter int NMAX = 16,
  parameter int IW   = 4
) (
  input  logic               clk,
  input  logic signed [31:0] coord,
  input  logic signed [31:0] origin,
  input  logic [31:0]        recip,
  input  logic [8:0]         npts,
  output logic [IW-1:0]      near,
  output logic [IW-1:0]      lo,
  output logic signed [25:0] frac
);
  logic        neg;
  logic [32:0] mag;
  logic signed [33:0] diff;
  logic [64:0] prod;
  logic [31:0] recip_d;
  logic [8:0]  npts_d;
  logic [8:0]  npts_dd;
  logic        neg_d;
  logic signed [50:0] r;
  logic signed [50:0] t;
  logic signed [50:0] a;
  logic [8:0] n_eff;
  logic [34:0] ip;
  logic [34:0] il;

  assign diff = 34'(coord) - 34'(origin);

  // Register magnitude and sign of the offset
  always_ff @(posedge clk) begin
    neg     <= diff < 0;
    mag     <= diff < 0 ? 33'(-diff) : diff[32:0];
    recip_d <= recip;
    npts_d  <= npts;
  end

  // Register the scaled magnitude
  always_ff @(posedge clk) begin
    prod    <= 65'(mag) * 65'(recip_d);
    neg_d   <= neg;
    npts_dd <= npts_d;
  end

  always_comb begin
    if (neg_d) begin
      r = -51'((prod + 65'(16'hFFFF)) >> 16);
    end else begin
      r = 51'(prod >> 16);
    end
    n_eff = npts_dd < 9'd2 ? 9'd2 : (npts_dd > 9'(NMAX) ? 9'(NMAX) : npts_dd);
    t  = r + 51'(32768);
    ip = (t < 0) ? 35'd0 : 35'(t >>> 16);
    if (ip > 35'(n_eff) - 35'd1) ip = 35'(n_eff) - 35'd1;
    il = (r < 0) ? 35'd0 : 35'(r >>> 16);
    if (il > 35'(n_eff) - 35'd2) il = 35'(n_eff) - 35'd2;
    a = r - (51'(il) <<< 16);
    if (a > 51'sd16777216) a = 51'sd16777216;
    if (a < -51'sd16777216) a = -51'sd16777216;
  end

  // Register the grid decisions
  always_ff @(posedge clk) begin
    near <= ip[IW-1:0];
    lo   <= il[IW-1:0];
    frac <= a[25:0];
  end
endmodule

>>> rtl/gtl_store.sv
// Table memory: eight identical copies, each giving one neighbour a cycle.
module gtl_store #(
  parameter int AW = 15,
  parameter int VW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [VW-1:0] wdata,
  input  logic [AW-1:0] raddr [8],
  output logic [VW-1:0] rdata [8]
);
  for (genvar g = 0; g < 8; g++) begin : g_bank
    logic [VW-1:0] mem [2**AW];
    always_ff @(posedge clk) begin
      if (we) begin
        mem[waddr] <= wdata;
      end
      rdata[g] <= mem[raddr[g]];
    end
  end
endmodule

>>> rtl/grid_table_trilinear_lookup.sv
// Grid table lookup with nearest and trilinear queries. One item is taken
// every cycle (busy stays low); a query result appears on result_strobe for
// one cycle, after the coordinate multiply stages, the table read and three
// registered blending steps with their multiply and round stages. The
// receiver cannot stall: every strobe must be captured. Loads pass through
// the write delay registers before they write the table and give no result;
// a query sees every load taken before it and none taken after it.
`include "grid_table_trilinear_lookup_assert.svh"
module grid_table_trilinear_lookup #(
  parameter int POL_MAX     = 2,
  parameter int INC_MAX     = 16,
  parameter int SPD_MAX     = 32,
  parameter int AZI_MAX     = 32,
  parameter int VALUE_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  op,
  input  logic        pol_sel,
  input  logic signed [31:0] inc_val,
  input  logic signed [31:0] spd_val,
  input  logic [15:0] azi_val,
  input  logic [14:0] entry_addr,
  input  logic signed [31:0] entry_value,
  output logic        result_strobe,
  output logic signed [31:0] result_value,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import gtl_pkg::*;

  localparam int VW    = VALUE_WIDTH < 32 ? VALUE_WIDTH : 32;
  localparam int IW    = INC_MAX > 1 ? $clog2(INC_MAX) : 1;
  localparam int SW    = SPD_MAX > 1 ? $clog2(SPD_MAX) : 1;
  localparam int CW    = AZI_MAX > 1 ? $clog2(AZI_MAX) : 1;
  localparam int PW    = POL_MAX > 1 ? $clog2(POL_MAX) : 1;
  localparam int DEPTH = POL_MAX * INC_MAX * SPD_MAX * AZI_MAX;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int LAT   = 11;

  cfg_t cfg;
  logic cfg_wr;

  // Configuration registers
  assign pready = 1'b1;
  assign busy   = 1'b0;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.inc_origin <= '0;
      cfg.inc_recip  <= 32'd65536;
      cfg.inc_points <= 5'd16;
      cfg.spd_origin <= '0;
      cfg.spd_recip  <= 32'd65536;
      cfg.spd_points <= 6'd32;
      cfg.azi_points <= 6'd32;
      cfg.pol_points <= 2'd2;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_INC_ORIGIN: cfg.inc_origin <= pwdata;
        REG_INC_RECIP:  cfg.inc_recip  <= pwdata;
        REG_INC_POINTS: cfg.inc_points <= pwdata[4:0];
        REG_SPD_ORIGIN: cfg.spd_origin <= pwdata;
        REG_SPD_RECIP:  cfg.spd_recip  <= pwdata;
        REG_SPD_POINTS: cfg.spd_points <= pwdata[5:0];
        REG_AZI_POINTS: cfg.azi_points <= pwdata[5:0];
        REG_POL_POINTS: cfg.pol_points <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[4:2])
      REG_INC_ORIGIN: prdata = cfg.inc_origin;
      REG_INC_RECIP:  prdata = cfg.inc_recip;
      REG_INC_POINTS: prdata = 32'(cfg.inc_points);
      REG_SPD_ORIGIN: prdata = cfg.spd_origin;
      REG_SPD_RECIP:  prdata = cfg.spd_recip;
      REG_SPD_POINTS: prdata = 32'(cfg.spd_points);
      REG_AZI_POINTS: prdata = 32'(cfg.azi_points);
      REG_POL_POINTS: prdata = 32'(cfg.pol_points);
      default:        prdata = '0;
    endcase
  end

  // Load path: delay the write through registers so it lands in the same slot as
  // the table read of a query taken at the same point in the stream
  logic          we;
  logic [AW-1:0] waddr;
  logic [VW-1:0] wdata;
  logic [2:0]    we_d;
  logic [AW-1:0] waddr_d [3];
  logic [VW-1:0] wdata_d [3];
  always_ff @(posedge clk) begin
    if (rst) begin
      we_d <= '0;
    end else begin
      we_d <= {we_d[1:0], start && op == OP_LOAD && 32'(entry_addr) < 32'(DEPTH)};
    end
    waddr_d[0] <= AW'(entry_addr);
    wdata_d[0] <= entry_value[VW-1:0];
    waddr_d[1] <= waddr_d[0];
    wdata_d[1] <= wdata_d[0];
    waddr_d[2] <= waddr_d[1];
    wdata_d[2] <= wdata_d[1];
  end
  assign we    = we_d[2];
  assign waddr = waddr_d[2];
  assign wdata = wdata_d[2];

  // Valid and op pipeline
  logic [LAT-1:0] vld;
  logic [1:0]     opq [LAT];
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start && (op == OP_NEAREST || op == OP_INTERP)};
    end
    opq[0] <= op;
    for (int k = 1; k < LAT; k++) opq[k] <= opq[k-1];
  end

  // Coordinate units: three stages each
  logic [IW-1:0]      i_near, i_lo;
  logic [SW-1:0]      s_near, s_lo;
  logic signed [25:0] i_frac, s_frac;

  gtl_index #(.NMAX(INC_MAX), .IW(IW)) u_inc (
    .clk(clk), .coord(inc_val), .origin(cfg.inc_origin), .recip(cfg.inc_recip),
    .npts(9'(cfg.inc_points)), .near(i_near), .lo(i_lo), .frac(i_frac)
  );
  gtl_index #(.NMAX(SPD_MAX), .IW(SW)) u_spd (
    .clk(clk), .coord(spd_val), .origin(cfg.spd_origin), .recip(cfg.spd_recip),
    .npts(9'(cfg.spd_points)), .near(s_near), .lo(s_lo), .frac(s_frac)
  );

  // Azimuth and polarization: product, then index, matched to three stages
  logic [21:0] ra;
  logic [8:0]  na;
  logic [15:0] fc_q [3];
  logic [CW-1:0] c_near_q, c_lo_q, c_hi_q;
  logic [CW-1:0] c_near_d [2], c_lo_d [2], c_hi_d [2];
  logic [PW-1:0] p_q [3];
  logic [8:0]  np_eff;
  logic [8:0]  na_comb;
  logic [8:0]  cn, cl, ch;

  always_comb begin
    na_comb = cfg.azi_points == 6'd0 ? 9'd1 :
              (9'(cfg.azi_points) > 9'(AZI_MAX) ? 9'(AZI_MAX) : 9'(cfg.azi_points));
    np_eff  = cfg.pol_points == 2'd0 ? 9'd1 :
              (9'(cfg.pol_points) > 9'(POL_MAX) ? 9'(POL_MAX) : 9'(cfg.pol_points));
    cn = 9'((ra + 22'd32768) >> 16);
    if (cn >= na) cn = cn - na;
    cl = 9'(ra >> 16);
    ch = cl + 9'd1;
    if (ch >= na) ch = 9'd0;
  end

  always_ff @(posedge clk) begin
    ra      <= 22'(azi_val) * 22'(na_comb);
    na      <= na_comb;
    p_q[0]  <= PW'((9'(pol_sel) > np_eff - 9'd1) ? np_eff - 9'd1 : 9'(pol_sel));
    p_q[1]  <= p_q[0];
    p_q[2]  <= p_q[1];
    fc_q[0] <= ra[15:0];
    fc_q[1] <= fc_q[0];
    fc_q[2] <= fc_q[1];
    c_near_d[0] <= CW'(cn);
    c_lo_d[0]   <= CW'(cl);
    c_hi_d[0]   <= CW'(ch);
    c_near_d[1] <= c_near_d[0];
    c_lo_d[1]   <= c_lo_d[0];
    c_hi_d[1]   <= c_hi_d[0];
  end
  assign c_near_q = c_near_d[1];
  assign c_lo_q   = c_lo_d[1];
  assign c_hi_q   = c_hi_d[1];

  // Form the eight read addresses (stage 3 outputs)
  function automatic logic [AW-1:0] mk_addr(input logic [PW-1:0] p, input logic [IW:0] i,
                                          input logic [SW:0] s, input logic [CW-1:0] c);
    logic [31:0] a;
    a = ((32'(p) * 32'(INC_MAX) + 32'(i)) * 32'(SPD_MAX) + 32'(s)) * 32'(AZI_MAX) + 32'(c);
    return AW'(a);
  endfunction

  logic [AW-1:0] raddr [8];
  logic          nearq;
  assign nearq = opq[2] == OP_NEAREST;
  always_comb begin
    for (int k = 0; k < 8; k++) begin
      if (nearq) begin
        raddr[k] = mk_addr(p_q[2], (IW+1)'(i_near), (SW+1)'(s_near), c_near_q);
      end else begin
        raddr[k] = mk_addr(p_q[2], (IW+1)'(i_lo) + (IW+1)'(k[2]),
                           (SW+1)'(s_lo) + (SW+1)'(k[1]), k[0] ? c_hi_q : c_lo_q);
      end
    end
  end

  logic [VW-1:0] rdata [8];
  gtl_store #(.AW(AW), .VW(VW)) u_store (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Align fractions with the blend stages
  logic signed [25:0] fs_q [3];
  logic signed [25:0] fi_q [5];
  always_ff @(posedge clk) begin
    fs_q[0] <= s_frac;
    fi_q[0] <= i_frac;
    for (int k = 1; k < 3; k++) fs_q[k] <= fs_q[k-1];
    for (int k = 1; k < 5; k++) fi_q[k] <= fi_q[k-1];
  end

  // Azimuth blend (four lanes), speed blend (two), incidence blend (one)
  logic signed [VW-1:0] va [4];
  logic signed [VW-1:0] vs [2];
  logic signed [VW-1:0] vi;
  for (genvar g = 0; g < 4; g++) begin : g_azi
    gtl_lerp #(.VW(VW)) u_l (.clk(clk), .lo(rdata[2*g]), .hi(rdata[2*g+1]),
      .frac(26'(fc_q[2])), .res(va[g]));
  end
  for (genvar g = 0; g < 2; g++) begin : g_spd
    gtl_lerp #(.VW(VW)) u_l (.clk(clk), .lo(va[2*g]), .hi(va[2*g+1]),
      .frac(fs_q[2]), .res(vs[g]));
  end
  gtl_lerp #(.VW(VW)) u_inc_l (.clk(clk), .lo(vs[0]), .hi(vs[1]),
    .frac(fi_q[4]), .res(vi));

  // Nearest value delayed to match the blend path
  logic signed [VW-1:0] nq [6];
  always_ff @(posedge clk) begin
    nq[0] <= rdata[0];
    for (int k = 1; k < 6; k++) nq[k] <= nq[k-1];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_strobe <= 1'b0;
    end else begin
      result_strobe <= vld[LAT-2];
    end
    result_value <= 32'((opq[LAT-2] == OP_NEAREST) ? nq[5] : vi);
  end

  `GT_ASSERT_IMPL(a_never_busy, clk, rst, 1'b1, !busy)
  `GT_ASSERT_NEXT(a_load_no_result, clk, rst, start && op == OP_LOAD, !vld[0])
  `GT_ASSERT_NEXT(a_strobe_follows, clk, rst, vld[LAT-2], result_strobe)
endmodule
